/* rtl/ler_pkg.sv */
// Shared types and constants for the line editor ring buffer.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package ler_pkg;

  // Control keys recognized by the editor.
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_BS     = 8'h08;
  localparam logic [7:0] KEY_DEL    = 8'h7F;
  localparam logic [7:0] KEY_WERASE = 8'h17;
  localparam logic [7:0] KEY_KILL   = 8'h15;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;

  localparam int unsigned KIND_W = 3;

  // Result kinds carried on the master-side tuser.
  typedef enum logic [KIND_W-1:0] {
    K_ECHO  = 3'd0,
    K_BELL  = 3'd1,
    K_ERASE = 3'd2,
    K_CRLF  = 3'd3,
    K_READ  = 3'd4,
    K_EMPTY = 3'd5,
    K_BUSY  = 3'd6
  } kind_e;

  // Input operation carried on the slave-side tuser.
  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Space, tab, newline, vertical tab, form feed and CR count as blanks.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= KEY_CR));
  endfunction

endpackage

`default_nettype wire

/* rtl/ler_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the character store of the line editor.
`default_nettype none

module ler_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/line_editor_ring_buffer.sv */
// Line editor over a circular character store. A plain key, CR, BS/DEL, busy or empty read
// loads the output register from S_DISPATCH; no new item is taken before S_IDLE returns. A
// read passes S_READ_ADDR, S_READ_DATA per delivered character and word erase S_WORD_ADDR,
// S_WORD_DATA per examined character, both paced by the single read port of the store; line
// erase emits one beat per cycle. A full output register stalls the sequencer. Reset (rst_ni
// low, asynchronous) empties the line and clears the pending flag; the store is not cleared.
`default_nettype none

module line_editor_ring_buffer #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave side.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [7:0] key_char, [14:8] max_chars, [15] zero
  input  wire logic        s_axis_tuser_i,   // [0] operation
  // Master side.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] data
  output logic [2:0]       m_axis_tuser_o,   // [2:0] kind
  output logic             m_axis_tlast_o    // last
);

  import ler_pkg::*;

  localparam int unsigned PTR_W = $clog2(STORE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(STORE_DEPTH - 1);
  localparam logic [PTR_W-1:0] FULL_LEN  = PTR_W'(STORE_DEPTH - 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ_ADDR,
    S_READ_DATA,
    S_WORD_ADDR,
    S_WORD_DATA,
    S_KILL
  } state_e;

  state_e           state_q, state_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] len_q, len_d;
  logic             pending_q, pending_d;
  logic             owed_q, owed_d;      // an erase beat is held back until its last flag is known
  logic [6:0]       want_q, want_d;
  op_e              op_q, op_d;
  logic [7:0]       key_q, key_d;
  logic [6:0]       max_q, max_d;
  logic             out_valid_q, out_valid_d;
  kind_e            out_kind_q, out_kind_d;
  logic [7:0]       out_data_q, out_data_d;
  logic             out_last_q, out_last_d;

  logic             out_free;
  logic             emit_en;
  kind_e            emit_kind;
  logic [7:0]       emit_data;
  logic             emit_last;
  logic             ram_we;
  logic [7:0]       ram_wdata;
  logic [PTR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  logic [PTR_W-1:0] wr_next, wr_prev, rd_next;

  assign wr_next = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PTR_W'(1);
  assign wr_prev = (wr_ptr_q == '0) ? LAST_SLOT : wr_ptr_q - PTR_W'(1);
  assign rd_next = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PTR_W'(1);

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign ram_raddr = ((state_q == S_READ_ADDR) || (state_q == S_READ_DATA)) ? rd_ptr_q : wr_prev;

  ler_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_ptr_q),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    len_d     = len_q;
    pending_d = pending_q;
    owed_d    = owed_q;
    want_d    = want_q;
    op_d      = op_q;
    key_d     = key_q;
    max_d     = max_q;
    emit_en   = 1'b0;
    emit_kind = K_ECHO;
    emit_data = '0;
    emit_last = 1'b1;
    ram_we    = 1'b0;
    ram_wdata = key_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d    = op_e'(s_axis_tuser_i);
          key_d   = s_axis_tdata_i[7:0];
          max_d   = s_axis_tdata_i[14:8];
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (op_q == OP_READ) begin
          if (!pending_q || (max_q == '0)) begin
            if (out_free) begin
              emit_en   = 1'b1;
              emit_kind = K_EMPTY;
              state_d   = S_IDLE;
            end
          end else begin
            want_d  = max_q;
            state_d = S_READ_ADDR;
          end
        end else if (pending_q) begin
          if (out_free) begin
            emit_en   = 1'b1;
            emit_kind = K_BUSY;
            state_d   = S_IDLE;
          end
        end else if (key_q == KEY_CR) begin
          if (out_free) begin
            ram_we    = 1'b1;
            ram_wdata = CH_NL;
            wr_ptr_d  = wr_next;
            len_d     = len_q + PTR_W'(1);
            pending_d = 1'b1;
            emit_en   = 1'b1;
            emit_kind = K_CRLF;
            state_d   = S_IDLE;
          end
        end else if ((key_q == KEY_BS) || (key_q == KEY_DEL)) begin
          if (out_free) begin
            emit_en = 1'b1;
            state_d = S_IDLE;
            if (len_q == '0) begin
              emit_kind = K_BELL;
            end else begin
              emit_kind = K_ERASE;
              wr_ptr_d  = wr_prev;
              len_d     = len_q - PTR_W'(1);
            end
          end
        end else if (key_q == KEY_WERASE) begin
          owed_d  = 1'b0;
          state_d = S_WORD_ADDR;
        end else if (key_q == KEY_KILL) begin
          state_d = S_KILL;
        end else if (out_free) begin
          emit_en = 1'b1;
          state_d = S_IDLE;
          if (len_q >= FULL_LEN) begin
            emit_kind = K_BELL;
          end else begin
            ram_we    = 1'b1;
            wr_ptr_d  = wr_next;
            len_d     = len_q + PTR_W'(1);
            emit_kind = K_ECHO;
            emit_data = key_q;
          end
        end
      end

      // The store has a registered read, so each character passes through this address state first.
      S_READ_ADDR: begin
        state_d = S_READ_DATA;
      end

      S_READ_DATA: begin
        if (out_free) begin
          emit_en   = 1'b1;
          emit_kind = K_READ;
          emit_data = ram_rdata;
          emit_last = (want_q == 7'd1) || (len_q == PTR_W'(1));
          rd_ptr_d  = rd_next;
          len_d     = len_q - PTR_W'(1);
          want_d    = want_q - 7'd1;
          if (len_q == PTR_W'(1)) begin
            pending_d = 1'b0;
          end
          state_d = emit_last ? S_IDLE : S_READ_ADDR;
        end
      end

      S_WORD_ADDR: begin
        if (len_q == '0) begin
          if (!owed_q) begin
            state_d = S_IDLE;
          end else if (out_free) begin
            emit_en   = 1'b1;
            emit_kind = K_ERASE;
            owed_d    = 1'b0;
            state_d   = S_IDLE;
          end
        end else begin
          state_d = S_WORD_DATA;
        end
      end

      // The owed beat goes out only once the next character shows whether erasing goes on.
      S_WORD_DATA: begin
        if (is_blank(ram_rdata)) begin
          if (!owed_q) begin
            state_d = S_IDLE;
          end else if (out_free) begin
            emit_en   = 1'b1;
            emit_kind = K_ERASE;
            owed_d    = 1'b0;
            state_d   = S_IDLE;
          end
        end else if (!owed_q || out_free) begin
          emit_en   = owed_q;
          emit_kind = K_ERASE;
          emit_last = 1'b0;
          owed_d    = 1'b1;
          wr_ptr_d  = wr_prev;
          len_d     = len_q - PTR_W'(1);
          state_d   = S_WORD_ADDR;
        end
      end

      S_KILL: begin
        if (len_q == '0) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          emit_en   = 1'b1;
          emit_kind = K_ERASE;
          emit_last = (len_q == PTR_W'(1));
          wr_ptr_d  = wr_prev;
          len_d     = len_q - PTR_W'(1);
          if (len_q == PTR_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (emit_en) begin
      out_valid_d = 1'b1;
      out_kind_d  = emit_kind;
      out_data_d  = emit_data;
      out_last_d  = emit_last;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      len_q       <= '0;
      pending_q   <= 1'b0;
      owed_q      <= 1'b0;
      want_q      <= '0;
      op_q        <= OP_KEY;
      key_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= K_ECHO;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      len_q       <= len_d;
      pending_q   <= pending_d;
      owed_q      <= owed_d;
      want_q      <= want_d;
      op_q        <= op_d;
      key_q       <= key_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_data_q  <= out_data_d;
      out_last_q  <= out_last_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

/* rtl/ler_checker.sv */
// Port-level checks for the line editor ring buffer, bound to the top level.
// Depends on ler_pkg for the result kinds.
`default_nettype none

module ler_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic [2:0] m_axis_tuser_o,
  input wire logic       m_axis_tlast_o
);

  import ler_pkg::*;

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // Every accepted item is decoded before another one is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted on consecutive cycles");

  // Only echo and read beats carry a character.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != K_ECHO) && (m_axis_tuser_o != K_READ)
      |-> (m_axis_tdata_o == 8'h00))
    else $error("nonzero data on a beat without a character");

  // Single-beat responses always close the item.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((m_axis_tuser_o == K_ECHO) || (m_axis_tuser_o == K_BELL)
      || (m_axis_tuser_o == K_CRLF) || (m_axis_tuser_o == K_EMPTY)
      || (m_axis_tuser_o == K_BUSY)) |-> m_axis_tlast_o)
    else $error("single-beat response without last");

  // No code beyond the busy kind is ever shown.
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 3'd7))
    else $error("undefined result kind");

endmodule

bind line_editor_ring_buffer ler_checker u_ler_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

`default_nettype wire
